@@ design/bfsp_pkg.sv @@
package bfsp_pkg;

  localparam int unsigned MaxNodes = 1024;
  localparam int unsigned MaxEdges = 4096;
  localparam int unsigned NodeW    = 11;
  localparam int unsigned NodeAw   = 11;
  localparam int unsigned EdgeAw   = 12;
  localparam int unsigned EdgeCntW = 13;
  localparam int unsigned NodeDepth = MaxNodes + 1;
  localparam int unsigned EdgeW    = 55;
  localparam logic signed [63:0] UnreachDist = 64'sd2147483647;

  typedef enum logic [2:0] {
    CMD_CLEAR = 3'd0,
    CMD_LOAD  = 3'd1,
    CMD_MARK  = 3'd2,
    CMD_RUN   = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CONVERGED = 2'd0,
    ST_PASS_LIMIT = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_READ,
    S_PASS,
    S_EREAD,
    S_SREAD,
    S_DREAD,
    S_UPDATE,
    S_DONE
  } state_e;

  function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                 logic signed [31:0] c);
    logic signed [64:0] s;
    s = {a[63], a} + {{33{c[31]}}, c};
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

endpackage

@@ design/bfsp_ram.sv @@
module bfsp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ design/bellman_ford_shortest_paths_core.sv @@
// Loads, marks and ignored commands never raise busy; clear sweeps the node
// stores while busy. A read returns its beat after S_READ and S_DONE.
// A run of passes over the edges returns its beat after S_DONE, with at most
// node_count-1 passes (node_count capped at 1024): each edge walks three
// chained memory reads (edge, source distance, destination distance) and a
// write-back. One command is in flight at a time.
// Reset clears the control state and acts as a clear (sweep, busy).
// Results appear for one cycle with result_valid_o; the receiver cannot stall.
module bellman_ford_shortest_paths_core import bfsp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [10:0]         cfg_wdata_i,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          cmd_i,
  input  logic [10:0]         node_a_i,
  input  logic [10:0]         node_b_i,
  input  logic signed [31:0]  edge_cost_i,
  input  logic                edge_usable_i,
  output logic                result_valid_o,
  output logic                result_kind_o,
  output logic [1:0]          run_status_o,
  output logic signed [63:0]  node_distance_o,
  output logic [10:0]         node_predecessor_o,
  output logic                node_reachable_o
);
  state_e state_q, state_d;
  logic [10:0] node_count_q;
  logic [EdgeCntW-1:0] edge_total_q, edge_total_d;
  logic overflow_q, overflow_d;
  logic [NodeAw-1:0] idx_q, idx_d;
  logic [EdgeAw-1:0] eidx_q, eidx_d;
  logic [10:0] pass_q, pass_d, n_eff_q, n_eff_d;
  logic changed_q, changed_d;
  logic [EdgeW-1:0] edge_q, edge_d;
  logic signed [63:0] cand_q, cand_d;
  logic valid_q, valid_d, rd_oob_q, rd_oob_d;

  logic e_we; logic [EdgeAw-1:0] e_addr; logic [EdgeW-1:0] e_wd, e_rd;
  logic d_we; logic [NodeAw-1:0] d_wa, d_ra; logic [63:0] d_wd, d_rd;
  logic [10:0] p_wd, p_rd;
  logic mark_we;
  logic dist_we; logic [NodeAw-1:0] dist_wa; logic [63:0] dist_wd;

  bfsp_ram #(.Width(EdgeW), .Depth(MaxEdges)) u_edge (
    .clk_i, .we_i(e_we), .waddr_i(e_addr), .wdata_i(e_wd),
    .raddr_i(e_addr), .rdata_o(e_rd));
  bfsp_ram #(.Width(64), .Depth(NodeDepth)) u_dist (
    .clk_i, .we_i(dist_we), .waddr_i(dist_wa), .wdata_i(dist_wd),
    .raddr_i(d_ra), .rdata_o(d_rd));
  // Marks write only the distance memory; the predecessor memory sees the
  // clear sweep and the relaxation writes alone.
  bfsp_ram #(.Width(11), .Depth(NodeDepth)) u_pred (
    .clk_i, .we_i(d_we), .waddr_i(d_wa), .wdata_i(p_wd),
    .raddr_i(d_ra), .rdata_o(p_rd));

  // Edge word: {usable, cost[31:0], dst[10:0], src[10:0]}.
  logic [10:0] e_src, e_dst;
  logic signed [31:0] e_cost;
  logic e_use, e_ok;
  assign e_src  = edge_q[10:0];
  assign e_dst  = edge_q[21:11];
  assign e_cost = edge_q[53:22];
  assign e_use  = edge_q[54];
  assign e_ok   = e_use && e_src != 11'd0 && e_src <= n_eff_q
                  && e_dst != 11'd0 && e_dst <= n_eff_q;

  logic accept;
  assign busy = (state_q != S_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; node_count_q <= 11'd1; edge_total_q <= '0;
      overflow_q <= 1'b0; idx_q <= '0; valid_q <= 1'b0;
    end else begin
      state_q <= state_d; edge_total_q <= edge_total_d;
      overflow_q <= overflow_d; idx_q <= idx_d; valid_q <= valid_d;
      if (cfg_we_i) node_count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    eidx_q <= eidx_d; pass_q <= pass_d; n_eff_q <= n_eff_d;
    changed_q <= changed_d; edge_q <= edge_d; cand_q <= cand_d;
    rd_oob_q <= rd_oob_d;
  end

  logic last_edge;
  assign last_edge = ({1'b0, eidx_q} + 13'd1) >= edge_total_q;

  logic pass_go;
  assign pass_go = pass_q < n_eff_q && changed_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) begin
        case (cmd_i)
          CMD_CLEAR: state_d = S_CLEAR;
          CMD_RUN:   state_d = S_PASS;
          CMD_READ:  state_d = S_READ;
          default:   state_d = S_IDLE;
        endcase
      end
      S_CLEAR: if (idx_q == NodeAw'(MaxNodes)) state_d = S_IDLE;
      S_READ:  state_d = S_DONE;
      // A pass over an empty edge list changes nothing and ends the run.
      S_PASS:  state_d = !pass_go ? S_DONE : (edge_total_q != '0) ? S_EREAD : S_PASS;
      S_EREAD: state_d = S_SREAD;
      S_SREAD: state_d = S_DREAD;
      S_DREAD: state_d = S_UPDATE;
      S_UPDATE: state_d = last_edge ? S_PASS : S_EREAD;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    edge_total_d = edge_total_q; overflow_d = overflow_q; idx_d = idx_q;
    eidx_d = eidx_q; pass_d = pass_q; n_eff_d = n_eff_q;
    changed_d = changed_q; edge_d = edge_q; cand_d = cand_q;
    rd_oob_d = rd_oob_q; valid_d = 1'b0;
    e_we = 1'b0; e_addr = eidx_q; e_wd = {edge_usable_i, edge_cost_i, node_b_i, node_a_i};
    d_we = 1'b0; d_wa = '0; d_ra = e_src; d_wd = UnreachDist; p_wd = '0;
    case (state_q)
      S_IDLE: if (accept) begin
        case (cmd_i)
          CMD_CLEAR: begin
            idx_d = '0; edge_total_d = '0; overflow_d = 1'b0;
          end
          CMD_LOAD: begin
            if (edge_total_q < EdgeCntW'(MaxEdges)) begin
              e_we = 1'b1; e_addr = edge_total_q[EdgeAw-1:0];
              edge_total_d = edge_total_q + 1'b1;
            end else overflow_d = 1'b1;
          end
          CMD_MARK: if (node_a_i <= 11'(MaxNodes)) begin
            // Marking writes distance zero and keeps the predecessor.
            d_ra = node_a_i;
          end
          CMD_RUN: begin
            n_eff_d = node_count_q > 11'(MaxNodes) ? 11'(MaxNodes) : node_count_q;
            pass_d = 11'd1; changed_d = 1'b1;
          end
          CMD_READ: begin
            rd_oob_d = node_a_i > 11'(MaxNodes); d_ra = node_a_i;
          end
          default: ;
        endcase
      end
      S_CLEAR: begin
        d_we = 1'b1; d_wa = idx_q; idx_d = idx_q + 1'b1;
      end
      S_PASS: begin
        if (pass_go) begin
          eidx_d = '0; changed_d = 1'b0;
        end
      end
      S_EREAD: e_addr = eidx_q;
      S_SREAD: begin edge_d = e_rd; d_ra = e_rd[10:0]; end
      S_DREAD: begin
        cand_d = sat_add(d_rd, e_cost);
        d_ra = e_dst;
        // An out-of-range or unusable edge, or a source distance at or above the sentinel, marks the edge as skipped.
        if (!e_ok || $signed(d_rd) >= UnreachDist) edge_d[54] = 1'b0;
      end
      S_UPDATE: begin
        if (e_use && cand_q < $signed(d_rd)) begin
          d_we = 1'b1; d_wa = e_dst; d_wd = cand_q; p_wd = e_src;
          changed_d = 1'b1;
        end
        eidx_d = eidx_q + 1'b1;
        if (last_edge) pass_d = pass_q + 1'b1;
      end
      S_DONE: valid_d = 1'b1;
      default: ;
    endcase
  end

  // The mark write is issued directly from the accept cycle.
  assign mark_we = accept && cmd_i == CMD_MARK && node_a_i <= 11'(MaxNodes);
  always_comb begin
    dist_we = d_we || mark_we;
    dist_wa = mark_we ? node_a_i : d_wa;
    dist_wd = mark_we ? 64'd0 : d_wd;
  end

  // Remember whether the last accepted command was a read to shape the beat.
  logic read_cmd_q, run_cmd_q, is_read_q;
  always_ff @(posedge clk_i) begin
    if (accept) is_read_q <= (cmd_i == CMD_READ);
  end
  assign read_cmd_q = is_read_q;
  assign run_cmd_q = !is_read_q;

  // Hold read data for the result beat.
  logic signed [63:0] rd_dist_q; logic [10:0] rd_pred_q;
  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) begin rd_dist_q <= d_rd; rd_pred_q <= p_rd; end
  end

  logic signed [63:0] out_dist;
  assign out_dist = rd_oob_q ? UnreachDist : rd_dist_q;
  assign result_valid_o     = valid_q;
  assign result_kind_o      = read_cmd_q;
  assign run_status_o       = read_cmd_q ? 2'd0 :
                              overflow_q ? ST_OVERFLOW :
                              changed_q ? ST_PASS_LIMIT : ST_CONVERGED;
  assign node_distance_o    = run_cmd_q ? 64'd0 : out_dist;
  assign node_predecessor_o = (run_cmd_q || rd_oob_q) ? 11'd0 : rd_pred_q;
  assign node_reachable_o   = run_cmd_q ? 1'b0 : (out_dist < UnreachDist);
endmodule

@@ dv/bellman_ford_shortest_paths_checker.sv @@
`timescale 1ns / 1ps

module bellman_ford_shortest_paths_checker import bfsp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [10:0]        cfg_wdata_i,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         cmd_i,
  input  logic [10:0]        node_a_i,
  input  logic [10:0]        node_b_i,
  input  logic signed [31:0] edge_cost_i,
  input  logic               edge_usable_i,
  input  logic               result_valid_o,
  input  logic               result_kind_o,
  input  logic [1:0]         run_status_o,
  input  logic signed [63:0] node_distance_o,
  input  logic [10:0]        node_predecessor_o,
  input  logic               node_reachable_o,
  output int                 error_count_o,
  output int                 pending_o
);

  localparam logic KindRun  = 1'b0;
  localparam logic KindRead = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [1:0]         status;
    logic signed [63:0] dist_val;
    logic [10:0]        pred;
    logic               reach;
  } node_result_t;

  node_result_t       want_q[$];
  logic [10:0]        node_count_q;
  logic [10:0]        e_src [0:MaxEdges-1];
  logic [10:0]        e_dst [0:MaxEdges-1];
  logic signed [31:0] e_cost[0:MaxEdges-1];
  logic               e_use [0:MaxEdges-1];
  int unsigned        edge_cnt;
  logic               ovf_q;
  logic signed [63:0] dist_q[0:MaxNodes];
  logic [10:0]        pred_q[0:MaxNodes];

  assign pending_o = want_q.size();

  function automatic logic signed [63:0] add_saturated(logic signed [63:0] a,
                                                       logic signed [31:0] c);
    logic signed [63:0] c64;
    logic signed [63:0] sum;
    c64 = 64'(c);
    sum = a + c64;
    if (c64 > 0 && sum < a) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (c64 < 0 && sum > a) return 64'sh8000_0000_0000_0000;
    return sum;
  endfunction

  task automatic wipe_graph();
    edge_cnt = 0;
    ovf_q = 1'b0;
    for (int i = 0; i <= MaxNodes; i++) begin
      dist_q[i] = UnreachDist;
      pred_q[i] = '0;
    end
  endtask

  task automatic relax_all(output logic [1:0] status);
    int unsigned n;
    logic changed;
    logic signed [63:0] cand;
    n = (node_count_q > MaxNodes) ? MaxNodes : node_count_q;
    changed = 1'b1;
    for (int unsigned pass = 1; pass < n && changed; pass++) begin
      changed = 1'b0;
      for (int unsigned e = 0; e < edge_cnt; e++) begin
        if (e_src[e] < 1 || e_src[e] > n || e_dst[e] < 1 || e_dst[e] > n) continue;
        if (dist_q[e_src[e]] >= UnreachDist || !e_use[e]) continue;
        cand = add_saturated(dist_q[e_src[e]], e_cost[e]);
        if (cand < dist_q[e_dst[e]]) begin
          dist_q[e_dst[e]] = cand;
          pred_q[e_dst[e]] = e_src[e];
          changed = 1'b1;
        end
      end
    end
    if (ovf_q) status = ST_OVERFLOW;
    else if (changed) status = ST_PASS_LIMIT;
    else status = ST_CONVERGED;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    node_result_t r;
    node_result_t got;
    logic [1:0] st;
    if (!rst_ni) begin
      node_count_q = 11'd1;
      wipe_graph();
      want_q.delete();
      error_count_o = 0;
    end else begin
      if (result_valid_o) begin
        got = '{result_kind_o, run_status_o, node_distance_o, node_predecessor_o,
                node_reachable_o};
        if (want_q.size() == 0) begin
          error_count_o++;
          if (error_count_o <= 10)
            $display("%0t: unexpected result beat kind=%0d", $realtime, got.kind);
        end else begin
          r = want_q.pop_front();
          if (got !== r) begin
            error_count_o++;
            if (error_count_o <= 10) begin
              $display("%0t: mismatch exp kind=%0d st=%0d dist=%0d pred=%0d reach=%0d",
                       $realtime, r.kind, r.status, r.dist_val, r.pred, r.reach);
              $display("%0t:          got kind=%0d st=%0d dist=%0d pred=%0d reach=%0d",
                       $realtime, got.kind, got.status, got.dist_val, got.pred,
                       got.reach);
            end
          end
        end
      end
      if (cfg_we_i) node_count_q = cfg_wdata_i;
      if (start && !busy) begin
        case (cmd_i)
          CMD_CLEAR: wipe_graph();
          CMD_LOAD: begin
            if (edge_cnt < MaxEdges) begin
              e_src[edge_cnt]  = node_a_i;
              e_dst[edge_cnt]  = node_b_i;
              e_cost[edge_cnt] = edge_cost_i;
              e_use[edge_cnt]  = edge_usable_i;
              edge_cnt++;
            end else begin
              ovf_q = 1'b1;
            end
          end
          CMD_MARK: if (node_a_i <= MaxNodes) dist_q[node_a_i] = '0;
          CMD_RUN: begin
            relax_all(st);
            want_q.push_back('{KindRun, st, 64'sd0, 11'd0, 1'b0});
          end
          CMD_READ: begin
            r = '{KindRead, 2'd0, UnreachDist, 11'd0, 1'b0};
            if (node_a_i <= MaxNodes) begin
              r.dist_val = dist_q[node_a_i];
              r.pred = pred_q[node_a_i];
            end
            r.reach = (r.dist_val < UnreachDist);
            want_q.push_back(r);
          end
          default: ;
        endcase
      end
    end
  end

  final begin
    if (want_q.size() != 0) begin
      $display("results still expected at end: %0d", want_q.size());
    end
  end

endmodule

@@ dv/bellman_ford_shortest_paths_core_test.sv @@
`timescale 1ns / 1ps

module bellman_ford_shortest_paths_core_test;
  import bfsp_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [10:0]        cfg_wdata_i = '0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         cmd_i = CMD_CLEAR;
  logic [10:0]        node_a_i = '0;
  logic [10:0]        node_b_i = '0;
  logic signed [31:0] edge_cost_i = '0;
  logic               edge_usable_i = 1'b0;
  logic               result_valid_o;
  logic               result_kind_o;
  logic [1:0]         run_status_o;
  logic signed [63:0] node_distance_o;
  logic [10:0]        node_predecessor_o;
  logic               node_reachable_o;
  int                 error_count;
  int                 pending;
  int                 item_count = 0;
  bit                 gaps_on = 1'b1;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  bellman_ford_shortest_paths_core dut (.*);

  bellman_ford_shortest_paths_checker u_checker (
    .*,
    .error_count_o(error_count),
    .pending_o(pending)
  );

  task automatic send_beat(logic [2:0] c, logic [10:0] a, logic [10:0] b,
                           logic signed [31:0] cost, logic use_bit);
    if (gaps_on && $urandom_range(0, 99) < 28) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start         <= 1'b1;
    cmd_i         <= c;
    node_a_i      <= a;
    node_b_i      <= b;
    edge_cost_i   <= cost;
    edge_usable_i <= use_bit;
    do @(posedge clk_i); while (busy);
    item_count++;
  endtask

  // Let every expected beat arrive and the block go quiet before a register write.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_node_count(logic [10:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_cost();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 32'sh7FFF_FFFF;
    if (r < 8) return 32'sh8000_0000;
    if (r < 14) return $urandom;
    return $signed($urandom_range(0, 40)) - 10;
  endfunction

  task automatic graph_phase();
    int unsigned n;
    int unsigned top;
    int unsigned s;
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) n = $urandom_range(2, 12);
    else if (r < 80) n = 0;
    else if (r < 85) n = 1;
    else if (r < 90) n = 1024;
    else if (r < 93) n = $urandom_range(1025, 2047);
    else n = $urandom_range(13, 60);
    set_node_count(11'(n));
    top = (n > 1024) ? 1025 : n + 1;
    if (n > 12 || $urandom_range(0, 99) < 85) send_beat(CMD_CLEAR, '0, '0, '0, 1'b0);
    s = $urandom_range(0, 2);
    for (int i = $urandom_range(0, (n > 12) ? 8 : 20); i > 0; i--) begin
      if ($urandom_range(0, 9) == 0) begin
        send_beat(CMD_LOAD, 11'($urandom), 11'($urandom), pick_cost(), 1'($urandom));
      end else begin
        if ($urandom_range(0, 2) == 0) s++;
        send_beat(CMD_LOAD, 11'(s), 11'($urandom_range(0, top)), pick_cost(),
                  $urandom_range(0, 99) < 85);
      end
    end
    for (int i = $urandom_range(1, 2); i > 0; i--) begin
      r = $urandom_range(0, 9);
      send_beat(CMD_MARK, (r == 0) ? 11'd0 : (r == 1) ? 11'($urandom_range(1025, 2047))
                : 11'($urandom_range(1, (top > 1) ? top - 1 : 1)), 11'($urandom),
                32'($urandom), 1'($urandom));
    end
    if ($urandom_range(0, 9) == 0)
      send_beat(3'($urandom_range(5, 7)), 11'($urandom), 11'($urandom), 32'($urandom),
                1'($urandom));
    send_beat(CMD_RUN, 11'($urandom), 11'($urandom), 32'($urandom), 1'($urandom));
    for (int i = $urandom_range(3, 6); i > 0; i--) begin
      r = $urandom_range(0, 19);
      send_beat(CMD_READ, (r == 0) ? 11'($urandom_range(1025, 2047))
                : 11'($urandom_range(0, top)), 11'($urandom), 32'($urandom),
                1'($urandom));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Small graph with edges out of range, an unusable edge and extreme costs.
    set_node_count(11'd4);
    send_beat(CMD_LOAD, 11'd0, 11'd1, 32'sd3, 1'b1);
    send_beat(CMD_LOAD, 11'd1, 11'd2, 32'sd5, 1'b1);
    send_beat(CMD_LOAD, 11'd1, 11'd3, 32'sh8000_0000, 1'b1);
    send_beat(CMD_LOAD, 11'd2, 11'd3, -32'sd3, 1'b1);
    send_beat(CMD_LOAD, 11'd3, 11'd4, 32'sh7FFF_FFFF, 1'b0);
    send_beat(CMD_LOAD, 11'd2, 11'd4, 32'sh7FFF_FFFF, 1'b1);
    send_beat(CMD_LOAD, 11'd5, 11'd1, -32'sd1, 1'b1);
    send_beat(CMD_LOAD, 11'd2047, 11'd2047, 32'sd1, 1'b1);
    send_beat(CMD_MARK, 11'd1, '0, '0, 1'b0);
    send_beat(CMD_MARK, 11'd2047, '1, '1, 1'b1);
    send_beat(3'd5, '1, '1, '1, 1'b1);
    send_beat(3'd7, '0, '0, '0, 1'b0);
    send_beat(CMD_RUN, '0, '0, '0, 1'b0);
    for (int i = 0; i <= 5; i++) send_beat(CMD_READ, 11'(i), '0, '0, 1'b0);
    send_beat(CMD_READ, 11'd1025, '0, '0, 1'b0);
    send_beat(CMD_READ, 11'd2047, '0, '0, 1'b0);

    // Pass limit with a single node and with no nodes.
    set_node_count(11'd1);
    send_beat(CMD_RUN, '0, '0, '0, 1'b0);
    set_node_count(11'd0);
    send_beat(CMD_RUN, '0, '0, '0, 1'b0);

    for (int p = 0; item_count < 1450; p++) begin
      gaps_on = !(p >= 10 && p < 20);
      graph_phase();
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (error_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ filelist.f @@
design/bfsp_pkg.sv
design/bfsp_ram.sv
design/bellman_ford_shortest_paths_core.sv
dv/bellman_ford_shortest_paths_checker.sv
dv/bellman_ford_shortest_paths_core_test.sv
